[hw/rtl/kplk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kplk_pkg
// Shared widths, request and operation codes, and base-character decoding
// for the k-mer pore level lookup.
// ----------------------------------------------------------------------------
package kplk_pkg;

    localparam int BASE_CHAR_W   = 8;
    localparam int ENTRY_INDEX_W = 12;
    localparam int LEVEL_W       = 16;
    localparam int KMER_LEN_W    = 3;
    localparam int RES_W         = LEVEL_W + ENTRY_INDEX_W + 1;

    localparam logic [KMER_LEN_W-1:0] KMER_LEN_RESET = 3'd6;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_BASE = 1'b1;

    typedef enum logic
    {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } kplk_op_t;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    localparam logic [BASE_CHAR_W-1:0] CHAR_UC_C = 8'h43;
    localparam logic [BASE_CHAR_W-1:0] CHAR_LC_C = 8'h63;
    localparam logic [BASE_CHAR_W-1:0] CHAR_UC_G = 8'h47;
    localparam logic [BASE_CHAR_W-1:0] CHAR_LC_G = 8'h67;
    localparam logic [BASE_CHAR_W-1:0] CHAR_UC_T = 8'h54;
    localparam logic [BASE_CHAR_W-1:0] CHAR_LC_T = 8'h74;

    function automatic logic [1:0] base_code(input logic [BASE_CHAR_W-1:0] ch);
        logic [1:0] code;
        unique case (ch)
            CHAR_UC_C, CHAR_LC_C: code = CODE_C;
            CHAR_UC_G, CHAR_LC_G: code = CODE_G;
            CHAR_UC_T, CHAR_LC_T: code = CODE_T;
            default:              code = CODE_A;
        endcase
        return code;
    endfunction

endpackage

[hw/rtl/kplk_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kplk_if
// Valid/ready channels: request stream in, result stream out.
// ----------------------------------------------------------------------------
interface kplk_req_if import kplk_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [BASE_CHAR_W-1:0]   base_char;
    logic                     start_of_read;
    logic                     last_base;
    logic [ENTRY_INDEX_W-1:0] entry_index;
    logic [LEVEL_W-1:0]       entry_level;

    modport source
    (
        output valid, req_type, base_char, start_of_read, last_base,
               entry_index, entry_level,
        input  ready
    );

    modport sink
    (
        input  valid, req_type, base_char, start_of_read, last_base,
               entry_index, entry_level,
        output ready
    );

endinterface

interface kplk_res_if import kplk_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [LEVEL_W-1:0]       level;
    logic [ENTRY_INDEX_W-1:0] kmer_index;
    logic                     last_level;

    modport source
    (
        output valid, level, kmer_index, last_level,
        input  ready
    );

    modport sink
    (
        input  valid, level, kmer_index, last_level,
        output ready
    );

endinterface

[hw/rtl/kmer_pore_level_lookup_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_pore_level_lookup_top
// Nucleotide stream to expected pore signal level lookup.
//
// req (valid/ready): a load request (req_type 0) writes entry_level into the
//   level table at entry_index; a base request (req_type 1) shifts base_char
//   into the rolling k-mer index. Once k bases of a read have arrived, each
//   base gives one result on res (level, kmer_index, last_level).
// cfg_wr_en/cfg_wr_data write the k-mer length (0 acts as 1, values above
//   MAX_KMER act as MAX_KMER); write it only while the block is idle.
// Throughput is one request per cycle while req.ready is high: the index
//   update is one shift and the lookup is one registered read of the level
//   RAM, whose result goes through the result FIFO to res.
// Reset clears the k-mer state and sets the k-mer length to 6; the level
//   table is not cleared and must be loaded before lookups.
// When res stalls, up to four results buffer at the output; beyond that the
//   operation queue fills and req.ready drops.
// ----------------------------------------------------------------------------
module kmer_pore_level_lookup_top import kplk_pkg::*; #(
    parameter int MAX_KMER   = 6,
    parameter int LEVEL_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    kplk_req_if.sink              req,
    kplk_res_if.source            res,
    input  logic                  cfg_wr_en,
    input  logic [KMER_LEN_W-1:0] cfg_wr_data
);

    localparam int OP_W     = 2 + 2 * MAX_KMER + LEVEL_BITS;
    localparam int Q_DEPTH  = 2;

    logic            q_push;
    logic [OP_W-1:0] q_push_data;
    logic            q_full;
    logic            q_pop;
    logic [OP_W-1:0] q_pop_data;
    logic            q_empty;

    kplk_front #(
        .MAX_KMER   (MAX_KMER),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_push      (q_push),
        .q_data      (q_push_data),
        .q_full      (q_full)
    );

    kplk_fifo #(
        .WIDTH (OP_W),
        .DEPTH (Q_DEPTH)
    ) u_op_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty),
        .count     ()
    );

    kplk_back #(
        .MAX_KMER   (MAX_KMER),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_pop_data),
        .q_pop   (q_pop),
        .res     (res)
    );

endmodule

[hw/rtl/kplk_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kplk_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kplk_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/kplk_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kplk_fifo
// Small register FIFO with occupancy count; DEPTH is a power of two.
// ----------------------------------------------------------------------------
module kplk_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = CNT_W'(count_reg + CNT_W'(push) - CNT_W'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> !full)
        else $error("fifo push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("fifo pop while empty");
`endif

endmodule

[hw/rtl/kplk_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kplk_front
// Accept requests, hold the k-mer length register, roll the k-mer index and
// queue table writes and lookups for the back end.
// ----------------------------------------------------------------------------
module kplk_front import kplk_pkg::*; #(
    parameter int MAX_KMER   = 6,
    parameter int LEVEL_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    kplk_req_if.sink                              req,
    input  logic                                  cfg_wr_en,
    input  logic [KMER_LEN_W-1:0]                 cfg_wr_data,
    output logic                                  q_push,
    output logic [2+2*MAX_KMER+LEVEL_BITS-1:0]    q_data,
    input  logic                                  q_full
);

    localparam int INDEX_BITS = 2 * MAX_KMER;
    localparam int K_W        = $clog2(MAX_KMER + 1);
    localparam int CMP_W      = (K_W > KMER_LEN_W) ? K_W : KMER_LEN_W;

    logic [KMER_LEN_W-1:0] kmer_len_reg, kmer_len_next;
    logic [INDEX_BITS-1:0] rolling_reg, rolling_next;
    logic [K_W-1:0]        seen_reg, seen_next;

    logic [K_W-1:0]        k_eff;
    logic [INDEX_BITS-1:0] mask;
    logic [1:0]            code;
    logic [INDEX_BITS-1:0] idx_upd;
    logic [K_W-1:0]        seen_upd;
    logic                  emit;
    logic                  accept;
    logic                  is_base;

    assign req.ready = !q_full;
    assign accept    = req.valid && req.ready;
    assign is_base   = (req.req_type == REQ_BASE);

    always_comb
    begin
        if (kmer_len_reg == '0)
        begin
            k_eff = K_W'(1);
        end
        else if (CMP_W'(kmer_len_reg) > CMP_W'(MAX_KMER))
        begin
            k_eff = K_W'(MAX_KMER);
        end
        else
        begin
            k_eff = K_W'(kmer_len_reg);
        end

        for (int i = 0; i < INDEX_BITS; i++)
        begin
            mask[i] = (K_W'(i >> 1) < k_eff);
        end

        code = base_code(req.base_char);

        if (req.start_of_read)
        begin
            idx_upd  = INDEX_BITS'(code) & mask;
            seen_upd = K_W'(1);
        end
        else
        begin
            idx_upd  = ((rolling_reg << 2) | INDEX_BITS'(code)) & mask;
            seen_upd = (seen_reg < k_eff) ? K_W'(seen_reg + 1'b1) : seen_reg;
        end
        if (seen_upd > k_eff)
        begin
            seen_upd = k_eff;
        end
        emit = (seen_upd >= k_eff);

        rolling_next = rolling_reg;
        seen_next    = seen_reg;
        if (accept && is_base)
        begin
            if (req.last_base)
            begin
                rolling_next = '0;
                seen_next    = '0;
            end
            else
            begin
                rolling_next = idx_upd;
                seen_next    = seen_upd;
            end
        end

        kmer_len_next = cfg_wr_en ? cfg_wr_data : kmer_len_reg;

        q_push = accept && (!is_base || emit);
        if (is_base)
        begin
            q_data = {OP_LOOKUP, req.last_base, idx_upd, LEVEL_BITS'(0)};
        end
        else
        begin
            q_data = {OP_WRITE, 1'b0, INDEX_BITS'(req.entry_index),
                      LEVEL_BITS'(req.entry_level)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_len_reg <= KMER_LEN_RESET;
            rolling_reg  <= '0;
            seen_reg     <= '0;
        end
        else
        begin
            kmer_len_reg <= kmer_len_next;
            rolling_reg  <= rolling_next;
            seen_reg     <= seen_next;
        end
    end

`ifndef SYNTHESIS
    a_read_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_base && req.last_base |=> rolling_reg == '0 && seen_reg == '0)
        else $error("k-mer state not cleared after last base");
`endif

endmodule

[hw/rtl/kplk_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kplk_back
// Drain queued operations: write level table entries, read levels for
// lookups and buffer results toward the output channel.
// ----------------------------------------------------------------------------
module kplk_back import kplk_pkg::*; #(
    parameter int MAX_KMER   = 6,
    parameter int LEVEL_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_empty,
    input  logic [2+2*MAX_KMER+LEVEL_BITS-1:0] q_data,
    output logic                               q_pop,
    kplk_res_if.source                         res
);

    localparam int INDEX_BITS = 2 * MAX_KMER;
    localparam int OP_W       = 2 + INDEX_BITS + LEVEL_BITS;
    localparam int RES_DEPTH  = 4;
    localparam int CNT_W      = $clog2(RES_DEPTH + 1);

    kplk_op_t              head_op;
    logic                  head_last;
    logic [INDEX_BITS-1:0] head_idx;
    logic [LEVEL_BITS-1:0] head_lvl;
    logic                  space;
    logic                  ram_we;
    logic                  ram_re;
    logic [LEVEL_BITS-1:0] ram_rdata;

    logic                     rd_valid_reg, rd_valid_next;
    logic                     rd_last_reg, rd_last_next;
    logic [ENTRY_INDEX_W-1:0] rd_index_reg, rd_index_next;

    logic             res_full;
    logic             res_empty;
    logic             res_pop;
    logic [CNT_W-1:0] res_count;
    logic [RES_W-1:0] res_push_data;
    logic [RES_W-1:0] res_pop_data;

    always_comb
    begin
        head_op   = kplk_op_t'(q_data[OP_W-1]);
        head_last = q_data[OP_W-2];
        head_idx  = q_data[LEVEL_BITS +: INDEX_BITS];
        head_lvl  = q_data[LEVEL_BITS-1:0];

        space  = (CNT_W'(res_count + CNT_W'(rd_valid_reg)) < CNT_W'(RES_DEPTH));
        ram_we = !q_empty && (head_op == OP_WRITE);
        ram_re = !q_empty && (head_op == OP_LOOKUP) && space;
        q_pop  = ram_we || ram_re;

        rd_valid_next = ram_re;
        rd_last_next  = ram_re ? head_last : rd_last_reg;
        rd_index_next = ram_re ? ENTRY_INDEX_W'(head_idx) : rd_index_reg;

        res_push_data = {LEVEL_W'(ram_rdata), rd_index_reg, rd_last_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_last_reg  <= rd_last_next;
        rd_index_reg <= rd_index_next;
    end

    kplk_ram #(
        .WIDTH (LEVEL_BITS),
        .DEPTH (1 << INDEX_BITS)
    ) u_level_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_idx),
        .wdata (head_lvl),
        .re    (ram_re),
        .raddr (head_idx),
        .rdata (ram_rdata)
    );

    kplk_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rd_valid_reg),
        .push_data (res_push_data),
        .full      (res_full),
        .pop       (res_pop),
        .pop_data  (res_pop_data),
        .empty     (res_empty),
        .count     (res_count)
    );

    assign res.valid      = !res_empty;
    assign res_pop        = res.valid && res.ready;
    assign res.level      = res_pop_data[RES_W-1 -: LEVEL_W];
    assign res.kmer_index = res_pop_data[ENTRY_INDEX_W:1];
    assign res.last_level = res_pop_data[0];

`ifndef SYNTHESIS
    a_result_credit: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> !res_full || res_pop)
        else $error("lookup landed with no result slot reserved");
`endif

endmodule
